// File: src/png_su_pkg.sv
package png_su_pkg;

    localparam int MAX_ROW_BYTES       = 16384;
    localparam int MAX_ROWS            = 4096;
    localparam int MAX_BYTES_PER_PIXEL = 4;

    localparam int ROW_BYTES_W = 15;
    localparam int BPP_W       = 3;
    localparam int ROWS_W      = 13;
    localparam int COL_W       = ROW_BYTES_W;
    localparam int ROWCNT_W    = ROWS_W - 1;
    localparam int X_W         = $clog2(MAX_ROW_BYTES);
    localparam int BPP_IDX_W   = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = $clog2(MQ_DEPTH);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_ROW_BYTES  = 2'd0;
    localparam logic [1:0] REG_BPP        = 2'd1;
    localparam logic [1:0] REG_IMAGE_ROWS = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic             err;
        logic             row_start;
        logic             first_row;
        logic             rend;
        logic             iend;
        logic [2:0]       filt;
        logic [X_W-1:0]   x;
        logic [7:0]       data;
    } entry_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       rend;
        logic       iend;
        logic       err;
    } result_t;

endpackage

// File: src/png_su_front.sv
module png_su_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [7:0]                           data_byte,
    input  logic [png_su_pkg::ROW_BYTES_W-1:0]   row_bytes_eff,
    input  logic [png_su_pkg::ROWS_W-1:0]        rows_eff,
    output logic                                 entry_push,
    output png_su_pkg::entry_t                   entry
);

    logic                                halted_reg, halted_next;
    logic [png_su_pkg::COL_W-1:0]        column_reg, column_next;
    logic [png_su_pkg::ROWCNT_W-1:0]     row_count_reg, row_count_next;
    logic [2:0]                          filt_reg, filt_next;
    logic                                first_row_reg, first_row_next;
    logic                                row_start_reg, row_start_next;
    logic                                rend;
    logic                                iend;
    logic [png_su_pkg::ROWS_W-1:0]       rows_done;

    assign rend      = (column_reg >= row_bytes_eff);
    assign rows_done = {1'b0, row_count_reg} + {{(png_su_pkg::ROWS_W-1){1'b0}}, 1'b1};
    assign iend      = rend && (rows_done >= rows_eff);

    always_comb
    begin
        halted_next    = halted_reg;
        column_next    = column_reg;
        row_count_next = row_count_reg;
        filt_next      = filt_reg;
        first_row_next = first_row_reg;
        row_start_next = row_start_reg;
        entry_push     = 1'b0;

        entry.err       = 1'b0;
        entry.row_start = row_start_reg;
        entry.first_row = first_row_reg;
        entry.rend      = rend;
        entry.iend      = iend;
        entry.filt      = filt_reg;
        entry.x         = png_su_pkg::X_W'(column_reg - png_su_pkg::COL_W'(1));
        entry.data      = data_byte;

        if (accept && !halted_reg)
        begin
            if (column_reg == '0)
            begin
                if (data_byte > {5'd0, png_su_pkg::FILT_PAETH})
                begin
                    halted_next = 1'b1;
                    entry_push  = 1'b1;
                    entry.err   = 1'b1;
                end
                else
                begin
                    filt_next      = data_byte[2:0];
                    column_next    = png_su_pkg::COL_W'(1);
                    row_start_next = 1'b1;
                end
            end
            else
            begin
                entry_push     = 1'b1;
                row_start_next = 1'b0;
                if (rend)
                begin
                    column_next = '0;
                    if (iend)
                    begin
                        row_count_next = '0;
                        first_row_next = 1'b1;
                    end
                    else
                    begin
                        row_count_next = row_count_reg + png_su_pkg::ROWCNT_W'(1);
                        first_row_next = 1'b0;
                    end
                end
                else
                begin
                    column_next = column_reg + png_su_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg    <= 1'b0;
            column_reg    <= '0;
            row_count_reg <= '0;
            filt_reg      <= png_su_pkg::FILT_NONE;
            first_row_reg <= 1'b1;
            row_start_reg <= 1'b0;
        end
        else
        begin
            halted_reg    <= halted_next;
            column_reg    <= column_next;
            row_count_reg <= row_count_next;
            filt_reg      <= filt_next;
            first_row_reg <= first_row_next;
            row_start_reg <= row_start_next;
        end
    end

endmodule

// File: src/png_su_queue.sv
module png_su_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  png_su_pkg::entry_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output png_su_pkg::entry_t rd_data,
    output logic               empty
);

    png_su_pkg::entry_t                  slot_reg [png_su_pkg::MQ_DEPTH];
    logic [png_su_pkg::MQ_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [png_su_pkg::MQ_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [png_su_pkg::MQ_AW:0]          count_reg, count_next;
    logic                                do_wr;
    logic                                do_rd;

    assign full    = (count_reg == (png_su_pkg::MQ_AW+1)'(png_su_pkg::MQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + png_su_pkg::MQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + png_su_pkg::MQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (png_su_pkg::MQ_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (png_su_pkg::MQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/png_su_back.sv
module png_su_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_vld,
    input  png_su_pkg::entry_t                   in_entry,
    output logic                                 in_take,
    input  logic [png_su_pkg::BPP_IDX_W-1:0]     bpp_idx,
    input  logic                                 out_full,
    output logic                                 out_push,
    output png_su_pkg::result_t                  out_data
);

    logic [7:0]                 mem [png_su_pkg::MAX_ROW_BYTES];
    logic [7:0]                 mem_q_reg;
    png_su_pkg::entry_t         stage_reg;
    logic                       stage_vld_reg, stage_vld_next;
    logic                       hit_reg;
    logic [7:0]                 fwd_val_reg;
    logic [7:0]                 left_reg   [png_su_pkg::MAX_BYTES_PER_PIXEL];
    logic [7:0]                 upleft_reg [png_su_pkg::MAX_BYTES_PER_PIXEL];

    logic                       retire;
    logic                       wr_row;
    logic [7:0]                 a;
    logic [7:0]                 b;
    logic [7:0]                 c;
    logic [8:0]                 avg_sum;
    logic [7:0]                 pa;
    logic [7:0]                 pb;
    logic [9:0]                 ab_sum;
    logic [9:0]                 cc_sum;
    logic [9:0]                 pc;
    logic [7:0]                 paeth;
    logic [7:0]                 pred;
    logic [7:0]                 val;

    assign retire  = stage_vld_reg && !out_full;
    assign in_take = in_vld && (!stage_vld_reg || retire);
    assign wr_row  = retire && !stage_reg.err;

    assign a = stage_reg.row_start ? 8'd0 : left_reg[bpp_idx];
    assign c = stage_reg.row_start ? 8'd0 : upleft_reg[bpp_idx];
    assign b = stage_reg.first_row ? 8'd0 : (hit_reg ? fwd_val_reg : mem_q_reg);

    always_comb
    begin
        avg_sum = {1'b0, a} + {1'b0, b};
        pa      = (b > c) ? b - c : c - b;
        pb      = (a > c) ? a - c : c - a;
        ab_sum  = {2'b00, a} + {2'b00, b};
        cc_sum  = {2'b00, c} + {2'b00, c};
        pc      = (ab_sum > cc_sum) ? ab_sum - cc_sum : cc_sum - ab_sum;
        if (({2'b00, pa} <= {2'b00, pb}) && ({2'b00, pa} <= pc))
        begin
            paeth = a;
        end
        else if ({2'b00, pb} <= pc)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end

        case (stage_reg.filt)
            png_su_pkg::FILT_SUB:   pred = a;
            png_su_pkg::FILT_UP:    pred = b;
            png_su_pkg::FILT_AVG:   pred = avg_sum[8:1];
            png_su_pkg::FILT_PAETH: pred = paeth;
            default:                pred = 8'd0;
        endcase

        val = (stage_reg.data + pred) & png_su_pkg::BYTE_MASK;
    end

    always_comb
    begin
        out_push = retire;
        if (stage_reg.err)
        begin
            out_data.pixel = 8'd0;
            out_data.rend  = 1'b0;
            out_data.iend  = 1'b0;
            out_data.err   = 1'b1;
        end
        else
        begin
            out_data.pixel = val;
            out_data.rend  = stage_reg.rend;
            out_data.iend  = stage_reg.iend;
            out_data.err   = 1'b0;
        end
    end

    always_comb
    begin
        stage_vld_next = stage_vld_reg;
        if (in_take)
        begin
            stage_vld_next = 1'b1;
        end
        else if (retire)
        begin
            stage_vld_next = 1'b0;
        end
    end

    // prior row store; a read that meets a write to the same byte takes the
    // forwarded value instead of the old word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mem_q_reg <= mem[in_entry.x];
            stage_reg <= in_entry;
            hit_reg   <= wr_row && (stage_reg.x == in_entry.x);
        end
        if (wr_row)
        begin
            mem[stage_reg.x] <= val;
        end
        if (retire)
        begin
            fwd_val_reg <= val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            for (int i = 0; i < png_su_pkg::MAX_BYTES_PER_PIXEL; i++)
            begin
                left_reg[i]   <= 8'd0;
                upleft_reg[i] <= 8'd0;
            end
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
            if (wr_row)
            begin
                for (int i = png_su_pkg::MAX_BYTES_PER_PIXEL - 1; i > 0; i--)
                begin
                    left_reg[i]   <= stage_reg.row_start ? 8'd0 : left_reg[i-1];
                    upleft_reg[i] <= stage_reg.row_start ? 8'd0 : upleft_reg[i-1];
                end
                left_reg[0]   <= val;
                upleft_reg[0] <= b;
            end
        end
    end

endmodule

// File: src/png_su_outq.sv
module png_su_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  png_su_pkg::result_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output png_su_pkg::result_t rd_data,
    output logic                empty
);

    png_su_pkg::result_t                 slot_reg [png_su_pkg::OQ_DEPTH];
    logic [png_su_pkg::OQ_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [png_su_pkg::OQ_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [png_su_pkg::OQ_AW:0]          count_reg, count_next;
    logic                                do_wr;
    logic                                do_rd;

    assign full    = (count_reg == (png_su_pkg::OQ_AW+1)'(png_su_pkg::OQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + png_su_pkg::OQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + png_su_pkg::OQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (png_su_pkg::OQ_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (png_su_pkg::OQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/png_scanline_unfilter_unit.sv
// A data byte reaches the result ports via the front queue write, the prior-row
// read stage and result queue write; a filter byte gives a result only as an error.
// Throughput: one byte per cycle unless the result queue is full, set by the predictor
// loop on the left neighbor and a read plus a write of the prior-row RAM per cycle.
// Reset: rst_n clears all control state, the registers read 1, the next byte is a
// filter byte of the first row; the prior-row RAM is not cleared.
module png_scanline_unfilter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [png_su_pkg::PADDR_W-1:0]     paddr,
    input  logic [png_su_pkg::PDATA_W-1:0]     pwdata,
    output logic [png_su_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         data_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         pixel_byte,
    output logic                               row_end,
    output logic                               image_end,
    output logic                               error
);

    logic [png_su_pkg::ROW_BYTES_W-1:0]  row_bytes_reg;
    logic [png_su_pkg::BPP_W-1:0]        bpp_reg;
    logic [png_su_pkg::ROWS_W-1:0]       image_rows_reg;
    logic                                cfg_wr;
    logic [1:0]                          reg_sel;

    logic [png_su_pkg::ROW_BYTES_W-1:0]  row_bytes_eff;
    logic [png_su_pkg::BPP_W-1:0]        bpp_eff;
    logic [png_su_pkg::ROWS_W-1:0]       rows_eff;
    logic [png_su_pkg::BPP_IDX_W-1:0]    bpp_idx;

    logic                                in_accept;
    logic                                entry_push;
    png_su_pkg::entry_t                  entry;
    png_su_pkg::entry_t                  head;
    logic                                mq_empty;
    logic                                head_take;
    logic                                res_push;
    png_su_pkg::result_t                 res;
    logic                                oq_full;
    png_su_pkg::result_t                 oq_head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_comb
    begin
        case (reg_sel)
            png_su_pkg::REG_ROW_BYTES:
                prdata = png_su_pkg::PDATA_W'(row_bytes_reg);
            png_su_pkg::REG_BPP:
                prdata = png_su_pkg::PDATA_W'(bpp_reg);
            png_su_pkg::REG_IMAGE_ROWS:
                prdata = png_su_pkg::PDATA_W'(image_rows_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg  <= png_su_pkg::ROW_BYTES_W'(1);
            bpp_reg        <= png_su_pkg::BPP_W'(1);
            image_rows_reg <= png_su_pkg::ROWS_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                png_su_pkg::REG_ROW_BYTES:
                    row_bytes_reg <= pwdata[png_su_pkg::ROW_BYTES_W-1:0];
                png_su_pkg::REG_BPP:
                    bpp_reg <= pwdata[png_su_pkg::BPP_W-1:0];
                png_su_pkg::REG_IMAGE_ROWS:
                    image_rows_reg <= pwdata[png_su_pkg::ROWS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // out-of-range settings saturate into the legal range
    always_comb
    begin
        if (row_bytes_reg == '0)
            row_bytes_eff = png_su_pkg::ROW_BYTES_W'(1);
        else if (row_bytes_reg > png_su_pkg::ROW_BYTES_W'(png_su_pkg::MAX_ROW_BYTES))
            row_bytes_eff = png_su_pkg::ROW_BYTES_W'(png_su_pkg::MAX_ROW_BYTES);
        else
            row_bytes_eff = row_bytes_reg;

        if (bpp_reg == '0)
            bpp_eff = png_su_pkg::BPP_W'(1);
        else if (bpp_reg > png_su_pkg::BPP_W'(png_su_pkg::MAX_BYTES_PER_PIXEL))
            bpp_eff = png_su_pkg::BPP_W'(png_su_pkg::MAX_BYTES_PER_PIXEL);
        else
            bpp_eff = bpp_reg;

        if (image_rows_reg == '0)
            rows_eff = png_su_pkg::ROWS_W'(1);
        else if (image_rows_reg > png_su_pkg::ROWS_W'(png_su_pkg::MAX_ROWS))
            rows_eff = png_su_pkg::ROWS_W'(png_su_pkg::MAX_ROWS);
        else
            rows_eff = image_rows_reg;
    end

    assign bpp_idx   = png_su_pkg::BPP_IDX_W'(bpp_eff - png_su_pkg::BPP_W'(1));
    assign in_accept = push && !full;

    png_su_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .data_byte     (data_byte),
        .row_bytes_eff (row_bytes_eff),
        .rows_eff      (rows_eff),
        .entry_push    (entry_push),
        .entry         (entry)
    );

    png_su_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (entry_push),
        .wr_data (entry),
        .full    (full),
        .rd_en   (head_take),
        .rd_data (head),
        .empty   (mq_empty)
    );

    png_su_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (!mq_empty),
        .in_entry (head),
        .in_take  (head_take),
        .bpp_idx  (bpp_idx),
        .out_full (oq_full),
        .out_push (res_push),
        .out_data (res)
    );

    png_su_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (oq_full),
        .rd_en   (pop),
        .rd_data (oq_head),
        .empty   (empty)
    );

    assign pixel_byte = oq_head.pixel;
    assign row_end    = oq_head.rend;
    assign image_end  = oq_head.iend;
    assign error      = oq_head.err;

endmodule
